/* rtl/pse_pkg.sv */
// Package for the stored-deflate PNG encoder.
// Holds the checksum step request type and the CRC-32 byte function.
// No dependencies.
`default_nettype none
package pse_pkg;

    localparam int          MaxSide  = 16384;
    localparam logic [31:0] CrcPoly  = 32'hEDB88320;
    localparam logic [31:0] CrcInit  = 32'hFFFFFFFF;
    localparam logic [16:0] AdlerMod = 17'd65521;

    // One byte handed to the shared checksum unit.
    typedef struct packed {
        logic       crc_en;
        logic       crc_restart;
        logic       adler_en;
        logic       adler_init;
        logic [7:0] data;
    } sum_req_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage
`default_nettype wire

/* rtl/png_stored_deflate_encoder_unit.sv */
// Top level of the stored-deflate PNG encoder: byte sequencer and output register.
// Depends on pse_pkg and pse_sum_unit.
`default_nettype none
// Usage:
// The slave stream takes items; tuser is the op (0 start a frame, 1 a pixel) and
// tdata carries the pixel bytes. The master stream gives one PNG file byte per
// item; tlast marks the last byte caused by an input item and tuser marks the
// final byte of the IEND chunk.
// The sequencer emits one byte per cycle, while the receiver does not stall,
// through the shared checksum unit, which updates the CRC-32 over the chunk
// types and data and the Adler-32 over the image bytes. An item is accepted in
// the idle state; the sequencer then emits the bytes it causes: a start item 43,
// a pixel 4 or 5 plus 5 for each stored-block header it opens, and the last
// pixel 20 more for the trailer. The output byte register sets this pace;
// s_tready is high only while idle; a pixel outside a frame is taken and dropped.
// When the receiver stalls, the output register holds its byte and the sequencer
// waits. Reset clears the sequencer, the frame state and the checksums; the
// image size registers reset to 1. The image size product and IDAT length are
// computed by a registered pipeline (raw_reg, blocks_reg, then idat_len_reg)
// that settles after a size write, long before the start sequence reads them.
module png_stored_deflate_encoder_unit #(
    parameter int MAX_SIDE = pse_pkg::MaxSide
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // blue, green, red, alpha
    input  wire logic        s_tuser,   // op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // out_byte
    output logic             m_tlast,   // run_last
    output logic             m_tuser,   // file_end
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_START = 2'd1;
    localparam logic [1:0] ST_PIX   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;
    localparam logic       REG_WIDTH  = 1'b0;
    localparam logic       REG_HEIGHT = 1'b1;
    localparam logic [14:0] SIDE_MAX = 15'(MAX_SIDE);

    logic [14:0] width_reg, height_reg;
    logic [14:0] w_clamp, h_clamp;
    logic [31:0] raw_reg, blocks_reg, idat_len_reg;
    logic [31:0] xsum;
    logic [16:0] rem;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  idx_reg, idx_next;
    logic [2:0]  sel_reg, sel_next;
    logic [2:0]  hcnt_reg, hcnt_next;
    logic        in_hdr_reg, in_hdr_next;
    logic [15:0] hlen_reg, hlen_next;
    logic [15:0] block_reg, block_next;
    logic [31:0] rawleft_reg, rawleft_next;
    logic [13:0] col_reg, col_next;
    logic [13:0] row_reg, row_next;
    logic        active_reg, active_next;
    logic [31:0] pix_reg;

    logic        out_valid_reg;
    logic [7:0]  out_data_reg;
    logic        out_last_reg, out_end_reg;

    logic        advance, emit, e_last, e_end;
    pse_pkg::sum_req_t req;
    logic [31:0] crc_value, adler_value, crc_final;
    logic [15:0] cur_len;
    logic [7:0]  sel_byte;

    pse_sum_unit u_sum (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .crc_value   (crc_value),
        .adler_value (adler_value)
    );

    always_comb
    begin
        w_clamp = (width_reg == 15'd0) ? 15'd1 : (width_reg > SIDE_MAX ? SIDE_MAX : width_reg);
        h_clamp = (height_reg == 15'd0) ? 15'd1 : (height_reg > SIDE_MAX ? SIDE_MAX : height_reg);
        // Number of stored blocks: ceil(raw / 65535) without a divider.
        xsum = raw_reg + 32'd65534;
        rem  = {1'b0, xsum[15:0]} + {1'b0, xsum[31:16]};
    end

    always_ff @(posedge clk)
    begin
        raw_reg      <= 32'({w_clamp, 2'b00} + 17'd1) * 32'(h_clamp);
        blocks_reg   <= {16'd0, xsum[31:16]} + ((rem >= 17'd65535) ? 32'd1 : 32'd0);
        idat_len_reg <= raw_reg + {blocks_reg[29:0], 2'b00} + blocks_reg + 32'd6;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 15'd1;
            height_reg <= 15'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    width_reg  <= width_reg;
            endcase
        end
    end

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign crc_final = ~crc_value;
    assign cur_len   = (rawleft_reg > 32'd65535) ? 16'hFFFF : rawleft_reg[15:0];

    always_comb
    begin
        case (sel_reg)
            3'd1:    sel_byte = pix_reg[23:16];
            3'd2:    sel_byte = pix_reg[15:8];
            3'd3:    sel_byte = pix_reg[7:0];
            3'd4:    sel_byte = pix_reg[31:24];
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        sel_next     = sel_reg;
        hcnt_next    = hcnt_reg;
        in_hdr_next  = in_hdr_reg;
        hlen_next    = hlen_reg;
        block_next   = block_reg;
        rawleft_next = rawleft_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        active_next  = active_reg;
        emit         = 1'b0;
        e_last       = 1'b0;
        e_end        = 1'b0;
        req          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (!s_tuser)
                    begin
                        state_next = ST_START;
                        idx_next   = 6'd0;
                    end
                    else if (active_reg)
                    begin
                        state_next  = ST_PIX;
                        sel_next    = (col_reg == 14'd0) ? 3'd0 : 3'd1;
                        in_hdr_next = 1'b0;
                    end
                end
            end
            ST_START:
            begin
                if (advance)
                begin
                    emit = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg <= 6'd7)
                    begin
                        case (idx_reg[2:0])
                            3'd0:    req.data = 8'd137;
                            3'd1:    req.data = 8'd80;
                            3'd2:    req.data = 8'd78;
                            3'd3:    req.data = 8'd71;
                            3'd4:    req.data = 8'd13;
                            3'd5:    req.data = 8'd10;
                            3'd6:    req.data = 8'd26;
                            default: req.data = 8'd10;
                        endcase
                    end
                    else if (idx_reg <= 6'd11)
                    begin
                        req.data = (idx_reg == 6'd11) ? 8'd13 : 8'd0;
                    end
                    else if (idx_reg <= 6'd15)
                    begin
                        req.crc_en = 1'b1;
                        req.crc_restart = (idx_reg == 6'd12);
                        case (idx_reg[1:0])
                            2'd0:    req.data = 8'd73;
                            2'd1:    req.data = 8'd72;
                            2'd2:    req.data = 8'd68;
                            default: req.data = 8'd82;
                        endcase
                    end
                    else if (idx_reg <= 6'd23)
                    begin
                        req.crc_en = 1'b1;
                        case (idx_reg[1:0])
                            2'd0:    req.data = 8'd0;
                            2'd1:    req.data = 8'd0;
                            2'd2:    req.data = idx_reg[2] ? {1'b0, h_clamp[14:8]}
                                                           : {1'b0, w_clamp[14:8]};
                            default: req.data = idx_reg[2] ? h_clamp[7:0] : w_clamp[7:0];
                        endcase
                    end
                    else if (idx_reg <= 6'd28)
                    begin
                        req.crc_en = 1'b1;
                        req.data = (idx_reg == 6'd24) ? 8'd8 :
                                   (idx_reg == 6'd25) ? 8'd6 : 8'd0;
                    end
                    else if (idx_reg <= 6'd32)
                    begin
                        case (idx_reg)
                            6'd29:   req.data = crc_final[31:24];
                            6'd30:   req.data = crc_final[23:16];
                            6'd31:   req.data = crc_final[15:8];
                            default: req.data = crc_final[7:0];
                        endcase
                    end
                    else if (idx_reg <= 6'd36)
                    begin
                        case (idx_reg)
                            6'd33:   req.data = idat_len_reg[31:24];
                            6'd34:   req.data = idat_len_reg[23:16];
                            6'd35:   req.data = idat_len_reg[15:8];
                            default: req.data = idat_len_reg[7:0];
                        endcase
                    end
                    else
                    begin
                        req.crc_en = 1'b1;
                        req.crc_restart = (idx_reg == 6'd37);
                        case (idx_reg)
                            6'd37:   req.data = 8'd73;
                            6'd38:   req.data = 8'd68;
                            6'd39:   req.data = 8'd65;
                            6'd40:   req.data = 8'd84;
                            6'd41:   req.data = 8'h78;
                            default: req.data = 8'h01;
                        endcase
                    end
                    if (idx_reg == 6'd42)
                    begin
                        e_last         = 1'b1;
                        state_next     = ST_IDLE;
                        req.adler_init = 1'b1;
                        block_next     = 16'd0;
                        rawleft_next   = raw_reg;
                        col_next       = 14'd0;
                        row_next       = 14'd0;
                        active_next    = 1'b1;
                    end
                end
            end
            ST_PIX:
            begin
                if (advance)
                begin
                    emit = 1'b1;
                    req.crc_en = 1'b1;
                    if (in_hdr_reg)
                    begin
                        case (hcnt_reg)
                            3'd1:    req.data = hlen_reg[7:0];
                            3'd2:    req.data = hlen_reg[15:8];
                            3'd3:    req.data = ~hlen_reg[7:0];
                            default: req.data = ~hlen_reg[15:8];
                        endcase
                        hcnt_next = hcnt_reg + 3'd1;
                        if (hcnt_reg == 3'd4)
                        begin
                            in_hdr_next = 1'b0;
                            block_next  = hlen_reg;
                        end
                    end
                    else if (block_reg == 16'd0 && rawleft_reg != 32'd0)
                    begin
                        // Stored-block header: final flag first.
                        req.data    = (rawleft_reg <= 32'd65535) ? 8'd1 : 8'd0;
                        in_hdr_next = 1'b1;
                        hcnt_next   = 3'd1;
                        hlen_next   = cur_len;
                    end
                    else
                    begin
                        req.data     = sel_byte;
                        req.adler_en = 1'b1;
                        if (block_reg != 16'd0)
                        begin
                            block_next = block_reg - 16'd1;
                        end
                        if (rawleft_reg != 32'd0)
                        begin
                            rawleft_next = rawleft_reg - 32'd1;
                        end
                        sel_next = sel_reg + 3'd1;
                        if (sel_reg == 3'd4)
                        begin
                            if ({1'b0, col_reg} + 15'd1 >= w_clamp)
                            begin
                                col_next = 14'd0;
                                if ({1'b0, row_reg} + 15'd1 >= h_clamp)
                                begin
                                    row_next   = 14'd0;
                                    state_next = ST_FIN;
                                    idx_next   = 6'd0;
                                end
                                else
                                begin
                                    row_next   = row_reg + 14'd1;
                                    state_next = ST_IDLE;
                                    e_last     = 1'b1;
                                end
                            end
                            else
                            begin
                                col_next   = col_reg + 14'd1;
                                state_next = ST_IDLE;
                                e_last     = 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                // Trailer: Adler-32, IDAT CRC, IEND chunk.
                if (advance)
                begin
                    emit = 1'b1;
                    idx_next = idx_reg + 6'd1;
                    if (idx_reg <= 6'd3)
                    begin
                        req.crc_en = 1'b1;
                        case (idx_reg[1:0])
                            2'd0:    req.data = adler_value[31:24];
                            2'd1:    req.data = adler_value[23:16];
                            2'd2:    req.data = adler_value[15:8];
                            default: req.data = adler_value[7:0];
                        endcase
                    end
                    else if (idx_reg <= 6'd11 && idx_reg >= 6'd8)
                    begin
                        req.data = 8'd0;
                    end
                    else if (idx_reg >= 6'd12 && idx_reg <= 6'd15)
                    begin
                        req.crc_en = 1'b1;
                        req.crc_restart = (idx_reg == 6'd12);
                        case (idx_reg[1:0])
                            2'd0:    req.data = 8'd73;
                            2'd1:    req.data = 8'd69;
                            2'd2:    req.data = 8'd78;
                            default: req.data = 8'd68;
                        endcase
                    end
                    else
                    begin
                        case (idx_reg[1:0])
                            2'd0:    req.data = crc_final[31:24];
                            2'd1:    req.data = crc_final[23:16];
                            2'd2:    req.data = crc_final[15:8];
                            default: req.data = crc_final[7:0];
                        endcase
                    end
                    if (idx_reg == 6'd19)
                    begin
                        e_last      = 1'b1;
                        e_end       = 1'b1;
                        active_next = 1'b0;
                        state_next  = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            pix_reg <= s_tdata;
        end
        if (emit)
        begin
            out_data_reg <= req.data;
            out_last_reg <= e_last;
            out_end_reg  <= e_end;
        end
        idx_reg  <= idx_next;
        sel_reg  <= sel_next;
        hcnt_reg <= hcnt_next;
        hlen_reg <= hlen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            in_hdr_reg    <= 1'b0;
            block_reg     <= 16'd0;
            rawleft_reg   <= 32'd0;
            col_reg       <= 14'd0;
            row_reg       <= 14'd0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            in_hdr_reg  <= in_hdr_next;
            block_reg   <= block_next;
            rawleft_reg <= rawleft_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            active_reg  <= active_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_end_reg;

endmodule
`default_nettype wire

/* rtl/pse_sum_unit.sv */
// Shared checksum unit: running CRC-32 and Adler-32, one byte per cycle.
// Depends on pse_pkg.
`default_nettype none
module pse_sum_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire pse_pkg::sum_req_t req,
    output logic [31:0]           crc_value,
    output logic [31:0]           adler_value
);

    logic [31:0] crc_reg, crc_next;
    logic [15:0] low_reg, low_next;
    logic [15:0] high_reg, high_next;
    logic [16:0] low_sum, high_sum;

    always_comb
    begin
        crc_next = crc_reg;
        if (req.crc_en)
        begin
            crc_next = pse_pkg::crc_byte(req.crc_restart ? pse_pkg::CrcInit : crc_reg,
                                         req.data);
        end
        low_sum = {1'b0, low_reg} + {9'd0, req.data};
        if (low_sum >= pse_pkg::AdlerMod)
        begin
            low_sum = low_sum - pse_pkg::AdlerMod;
        end
        high_sum = {1'b0, high_reg} + low_sum;
        if (high_sum >= pse_pkg::AdlerMod)
        begin
            high_sum = high_sum - pse_pkg::AdlerMod;
        end
        low_next  = low_reg;
        high_next = high_reg;
        if (req.adler_init)
        begin
            low_next  = 16'd1;
            high_next = 16'd0;
        end
        else if (req.adler_en)
        begin
            low_next  = low_sum[15:0];
            high_next = high_sum[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= pse_pkg::CrcInit;
            low_reg  <= 16'd1;
            high_reg <= 16'd0;
        end
        else
        begin
            crc_reg  <= crc_next;
            low_reg  <= low_next;
            high_reg <= high_next;
        end
    end

    assign crc_value   = crc_reg;
    assign adler_value = {high_reg, low_reg};

endmodule
`default_nettype wire

/* tb/png_stored_deflate_encoder_unit_test.sv */
// Self-checking testbench for png_stored_deflate_encoder_unit.
// Needs pse_pkg and the encoder RTL; it predicts every PNG byte and compares it with the output.
`timescale 1ns / 1ps
`default_nettype none
module png_stored_deflate_encoder_unit_test;

    // Item kinds on the input tuser and register indexes of the write port.
    localparam logic OP_START = 1'b0;
    localparam logic OP_PIXEL = 1'b1;
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Longest run of cycles without a transfer on either stream before the run is declared hung.
    localparam int HANG_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // blue, green, red, alpha
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic        m_tlast;   // run_last
    logic        m_tuser;   // file_end
    logic        cfg_we;
    logic        cfg_index;
    logic [14:0] cfg_data;

    png_stored_deflate_encoder_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // One expected byte of the PNG file, with its end-of-item and end-of-file marks.
    typedef struct {
        logic [7:0] value;
        logic       item_end;
        logic       file_end;
    } png_byte_t;

    png_byte_t png_bytes_due[$];    // bytes the encoder still owes, oldest first
    png_byte_t item_bytes[$];       // bytes caused by the item being predicted

    int error_count;
    int bytes_checked;
    int items_sent;
    int frames_closed;
    int hang_count;

    // Mirror of the encoder state, kept by the predictor.
    logic [14:0] size_w;
    logic [14:0] size_h;
    logic [31:0] crc_acc;
    logic [31:0] adler_lo;
    logic [31:0] adler_hi;
    logic [31:0] block_left;
    logic [31:0] raw_left;
    logic [31:0] col_idx;
    logic [31:0] row_idx;
    logic        in_frame;

    // Idling modes: when set, that side never pauses.
    logic tx_steady;
    logic rx_steady;
    int   rx_hold = 0;

    logic [7:0] pse_sig [8] = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h, expected 0x%0h (byte %0d)", what, got, want,
                 bytes_checked);
        error_count++;
    endtask

    // A size of zero counts as one, and anything past the maximum side as the maximum.
    function automatic logic [31:0] side_of(input logic [14:0] v);
        if (v == 15'd0)
            return 32'd1;
        if (v > 15'(pse_pkg::MaxSide))
            return pse_pkg::MaxSide;
        return {17'd0, v};
    endfunction

    function automatic logic [31:0] crc_next(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] acc;
        acc = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            acc = acc[0] ? ((acc >> 1) ^ 32'hEDB88320) : (acc >> 1);
        return acc;
    endfunction

    task automatic put_byte(input logic [7:0] b, input bit in_crc);
        png_byte_t e;
        if (in_crc)
            crc_acc = crc_next(crc_acc, b);
        e.value    = b;
        e.item_end = 1'b0;
        e.file_end = 1'b0;
        item_bytes.push_back(e);
    endtask

    task automatic put_word(input logic [31:0] v, input bit in_crc);
        for (int s = 24; s >= 0; s -= 8)
            put_byte(v[s +: 8], in_crc);
    endtask

    task automatic put_tag(input logic [31:0] tag);
        put_word(tag, 1'b1);
    endtask

    // Image data byte: opens a stored block when the previous one is used up.
    task automatic put_image_byte(input logic [7:0] b);
        logic [31:0] len;
        logic [15:0] inv;
        if (block_left == 0 && raw_left > 0)
        begin
            len = (raw_left > 32'd65535) ? 32'd65535 : raw_left;
            inv = ~len[15:0];
            put_byte((raw_left <= 32'd65535) ? 8'd1 : 8'd0, 1'b1);
            put_byte(len[7:0], 1'b1);
            put_byte(len[15:8], 1'b1);
            put_byte(inv[7:0], 1'b1);
            put_byte(inv[15:8], 1'b1);
            block_left = len;
        end
        put_byte(b, 1'b1);
        adler_lo = (adler_lo + b) % 65521;
        adler_hi = (adler_hi + adler_lo) % 65521;
        if (block_left > 0)
            block_left--;
        if (raw_left > 0)
            raw_left--;
    endtask

    task automatic open_frame();
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] raw;
        logic [31:0] blocks;
        w = side_of(size_w);
        h = side_of(size_h);
        raw = (4 * w + 1) * h;
        blocks = (raw + 65534) / 65535;
        foreach (pse_sig[k])
            put_byte(pse_sig[k], 1'b0);
        put_word(32'd13, 1'b0);
        crc_acc = 32'hFFFFFFFF;
        put_tag("IHDR");
        put_word(w, 1'b1);
        put_word(h, 1'b1);
        put_byte(8'd8, 1'b1);
        put_byte(8'd6, 1'b1);
        put_byte(8'd0, 1'b1);
        put_byte(8'd0, 1'b1);
        put_byte(8'd0, 1'b1);
        put_word(~crc_acc, 1'b0);
        put_word(2 + raw + blocks * 5 + 4, 1'b0);
        crc_acc = 32'hFFFFFFFF;
        put_tag("IDAT");
        put_byte(8'h78, 1'b1);
        put_byte(8'h01, 1'b1);
        adler_lo   = 1;
        adler_hi   = 0;
        block_left = 0;
        raw_left   = raw;
        col_idx    = 0;
        row_idx    = 0;
        in_frame   = 1'b1;
    endtask

    task automatic close_frame();
        put_word({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
        put_word(~crc_acc, 1'b0);
        put_word(32'd0, 1'b0);
        crc_acc = 32'hFFFFFFFF;
        put_tag("IEND");
        put_word(~crc_acc, 1'b0);
        item_bytes[item_bytes.size() - 1].file_end = 1'b1;
        in_frame = 1'b0;
        frames_closed++;
    endtask

    // Works out the bytes one accepted item causes and queues them; returns their count.
    task automatic predict_png_bytes(input logic op, input logic [31:0] px, output int n);
        item_bytes.delete();
        if (op == OP_START)
            open_frame();
        else if (in_frame)
        begin
            if (col_idx == 0)
                put_image_byte(8'd0);
            put_image_byte(px[23:16]);
            put_image_byte(px[15:8]);
            put_image_byte(px[7:0]);
            put_image_byte(px[31:24]);
            if (col_idx + 1 >= side_of(size_w))
            begin
                col_idx = 0;
                if (row_idx + 1 >= side_of(size_h))
                begin
                    row_idx = 0;
                    close_frame();
                end
                else
                    row_idx++;
            end
            else
                col_idx++;
        end
        n = item_bytes.size();
        if (n > 0)
            item_bytes[n - 1].item_end = 1'b1;
        foreach (item_bytes[k])
            png_bytes_due.push_back(item_bytes[k]);
    endtask

    // Sends one item. It is entered and left at a falling edge; tvalid stays high on
    // leaving so that a following item with no gap keeps it up without a dip.
    task automatic send_item(input logic op, input logic [31:0] px, input int want);
        int gap;
        int n;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= px;
        do
            @(posedge clk);
        while (!s_tready);
        predict_png_bytes(op, px, n);
        items_sent++;
        if (want >= 0 && n != want)
            report("bytes caused by item", n, want);
        @(negedge clk);
    endtask

    // Waits until every owed byte has arrived, then lets the sequencer settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (png_bytes_due.size() != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Register writes happen only with the encoder idle; the size pipeline then settles.
    task automatic write_size(input logic idx, input logic [14:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_WIDTH)
            size_w = v;
        else
            size_h = v;
        repeat (8) @(negedge clk);
    endtask

    // Output side: stalls drawn per byte, applied at the falling edge.
    always @(negedge clk)
    begin
        m_tready <= (rx_hold == 0);
    end

    always @(posedge clk)
    begin
        png_byte_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            rx_hold <= rx_steady ? 0 : $urandom_range(0, 6);
            if (png_bytes_due.size() == 0)
                report("unexpected byte", m_tdata, 0);
            else
            begin
                e = png_bytes_due.pop_front();
                if (m_tdata !== e.value)
                    report("out_byte", m_tdata, e.value);
                if (m_tlast !== e.item_end)
                    report("run_last", m_tlast, e.item_end);
                if (m_tuser !== e.file_end)
                    report("file_end", m_tuser, e.file_end);
            end
            bytes_checked++;
        end
        else if (rx_hold > 0)
            rx_hold <= rx_hold - 1;
    end

    // A run with nothing moving on either side for too long has hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            hang_count <= 0;
        else if (hang_count >= HANG_LIMIT)
        begin
            $display("Timeout: no item moved for %0d cycles", HANG_LIMIT);
            $display("png_stored_deflate_encoder_unit verification failed");
            $finish;
        end
        else
            hang_count <= hang_count + 1;
    end

    // Directed rows: a register write or an item, with the byte count typed in where
    // it is plain to see (start 43; one-pixel frame 30; pixel opening a block 10).
    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;
    typedef struct {
        row_kind_t   kind;
        logic        sel;    // op for an item, register index for a write
        logic [31:0] val;
        int          want;   // -1 when left to the predictor
    } stim_row_t;

    stim_row_t stim_rows [] = '{
        '{ROW_ITEM, OP_PIXEL,   32'h12345678, 0},   // pixel with no frame open
        '{ROW_ITEM, OP_START,   32'hFFFFFFFF, 43},  // pixel fields ignored on a start
        '{ROW_ITEM, OP_PIXEL,   32'h00000000, 30},
        '{ROW_ITEM, OP_PIXEL,   32'hFFFFFFFF, 0},   // frame already closed
        '{ROW_ITEM, OP_START,   32'h0,        43},
        '{ROW_ITEM, OP_START,   32'h0,        43},  // restart abandons the frame
        '{ROW_ITEM, OP_PIXEL,   32'hFFFFFFFF, 30},
        '{ROW_CFG,  REG_WIDTH,  32'd0,        -1},  // zero sizes count as one
        '{ROW_CFG,  REG_HEIGHT, 32'd0,        -1},
        '{ROW_ITEM, OP_START,   32'h0,        43},
        '{ROW_ITEM, OP_PIXEL,   32'hA5C3_3C5A, 30},
        '{ROW_CFG,  REG_WIDTH,  32'd32767,    -1},  // clamps to the largest side
        '{ROW_CFG,  REG_HEIGHT, 32'd16384,    -1},
        '{ROW_ITEM, OP_START,   32'h0,        43},
        '{ROW_ITEM, OP_START,   32'h0,        43},
        '{ROW_ITEM, OP_PIXEL,   32'h5A3C_C3A5, 10},
        '{ROW_ITEM, OP_PIXEL,   32'h0F0F_F0F0, 4},
        '{ROW_CFG,  REG_WIDTH,  32'd2,        -1},
        '{ROW_CFG,  REG_HEIGHT, 32'd2,        -1},
        '{ROW_ITEM, OP_START,   32'h0,        43},
        '{ROW_ITEM, OP_PIXEL,   32'h01020304, 10},
        '{ROW_ITEM, OP_PIXEL,   32'h80808080, 4},
        '{ROW_ITEM, OP_PIXEL,   32'h7F7F7F7F, 5},
        '{ROW_CFG,  REG_HEIGHT, 32'd1,        -1},  // shrink while the frame is open
        '{ROW_ITEM, OP_PIXEL,   32'hDEADBEEF, 24}
    };

    // One frame with random pixels; now and then it is cut short or salted with strays.
    task automatic random_frame();
        int pixels;
        int cut;
        pixels = side_of(size_w) * side_of(size_h);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, pixels - 1) : pixels;
        tx_steady = ($urandom_range(0, 3) == 0);
        rx_steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0)
            send_item(OP_PIXEL, $urandom, -1);
        send_item(OP_START, $urandom, -1);
        for (int k = 0; k < cut; k++)
            send_item(OP_PIXEL, $urandom, -1);
    endtask

    initial
    begin
        error_count   = 0;
        items_sent    = 0;
        frames_closed = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        size_w   = 15'd1;
        size_h   = 15'd1;
        crc_acc  = 32'hFFFFFFFF;
        adler_lo = 1;
        adler_hi = 0;
        block_left = 0;
        raw_left   = 0;
        col_idx    = 0;
        row_idx    = 0;
        in_frame   = 1'b0;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        s_tuser   = OP_START;
        cfg_we    = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data  = 15'd0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        foreach (stim_rows[k])
        begin
            if (stim_rows[k].kind == ROW_CFG)
                write_size(stim_rows[k].sel, stim_rows[k].val[14:0]);
            else
                send_item(stim_rows[k].sel, stim_rows[k].val, stim_rows[k].want);
        end

        // Random frames of small sizes; each waits for the previous file to drain.
        while (items_sent < 230)
        begin
            write_size(REG_WIDTH, ($urandom_range(0, 4) == 0) ?
                       15'($urandom_range(0, 20)) : 15'($urandom_range(1, 6)));
            write_size(REG_HEIGHT, 15'($urandom_range(0, 4)));
            random_frame();
        end

        drain();
        repeat (50) @(negedge clk);
        $display("Sent %0d items, checked %0d PNG bytes, %0d files completed,",
                 items_sent, bytes_checked, frames_closed);
        $display("including size clamping, restarts, mid-frame resizing and non-final blocks.");
        if (error_count == 0 && png_bytes_due.size() == 0)
            $display("png_stored_deflate_encoder_unit verification clean");
        else
            $display("png_stored_deflate_encoder_unit verification failed");
        $finish;
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/pse_pkg.sv
rtl/pse_sum_unit.sv
rtl/png_stored_deflate_encoder_unit.sv
tb/png_stored_deflate_encoder_unit_test.sv
